@@ rtl/zdp_pkg.sv @@
// ----------------------------------------------------------------------------
// zdp_pkg: shared types and constants of the zone distance packetizer
// Default sizes, header constants, command codes and state types used by
// the front end, the command queue and the transmit engine.
// ----------------------------------------------------------------------------
package zdp_pkg;

    localparam int QUEUE_DEPTH_DEF  = 8;
    localparam int PACKET_BYTES_DEF = 48;
    localparam int HEADER_BYTES     = 4;
    localparam int CMDQ_DEPTH       = 2;

    localparam logic [7:0] PKT_TYPE    = 8'd1;
    localparam logic [7:0] PKT_ID      = 8'd0;
    localparam logic [7:0] EXP_CNT_16  = 8'd1;
    localparam logic [7:0] EXP_CNT_64  = 8'd3;
    localparam logic [6:0] ZONES_16    = 7'd16;
    localparam logic [6:0] ZONES_64    = 7'd64;

    // Header byte positions.
    localparam logic [1:0] HDR_TYPE_POS = 2'd0;
    localparam logic [1:0] HDR_NUM_POS  = 2'd1;
    localparam logic [1:0] HDR_CNT_POS  = 2'd2;
    localparam logic [1:0] HDR_ID_POS   = 2'd3;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;
    localparam logic MODE_16     = 1'b1;

    typedef enum logic {
        CMD_COMMIT = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        F_IDLE,
        F_WR_HI,
        F_PAD,
        F_HDR,
        F_ISSUE
    } t_front_state;

    typedef enum logic {
        B_IDLE,
        B_STREAM
    } t_back_state;

endpackage

@@ rtl/zone_distance_packetizer_fifo.sv @@
// ----------------------------------------------------------------------------
// zone_distance_packetizer_fifo: zone distance packet framer with packet queue
// Packs per-zone distances into fixed-length headed packets, queues them and
// streams the head packet byte by byte on a transmit tick.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries a word that is either one
// zone distance or a transmit tick. Output channel (o_out_valid / i_out_stall)
// carries one packet byte per word, o_last_byte on the final byte.
// A distance's two bytes go through the single write port of the packet
// store, low byte first. Closing a packet zero fills the padding bytes,
// writes the four header bytes and queues the commit; the next distance
// waits until the transmit engine has taken that commit. A tick goes
// straight into the command queue. When the engine takes it and a packet
// is waiting, the first byte is read through the store's registered port
// into the output register, and the rest follow one per cycle from the
// read port while the receiver does not stall; a tick on an empty queue gives nothing.
// A packet that finds the queue full is dropped.
// Synchronous reset clears all control state and empties the queue; the
// packet store needs no clearing. While the receiver stalls, the current byte
// holds, one more byte waits at the store output, and reading pauses.
// ----------------------------------------------------------------------------
module zone_distance_packetizer_fifo #(
    parameter int QUEUE_DEPTH  = zdp_pkg::QUEUE_DEPTH_DEF,
    parameter int PACKET_BYTES = zdp_pkg::PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [15:0] i_distance,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_byte
);

    import zdp_pkg::*;

    localparam int NSLOT = QUEUE_DEPTH + 1;
    localparam int PW    = $clog2(NSLOT);
    localparam int DEPTH = NSLOT * PACKET_BYTES;
    localparam int AW    = $clog2(DEPTH);

    logic          w_push;
    t_cmd          w_push_cmd;
    logic          w_fifo_full;
    logic          w_cmd_pop;
    logic          w_cmd_valid;
    t_cmd          w_cmd;
    logic          w_commit_done;
    logic [PW-1:0] w_tail;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    w_rd_data;

    zdp_front #(
        .PACKET_BYTES (PACKET_BYTES),
        .PW           (PW),
        .AW           (AW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_distance    (i_distance),
        .i_commit_done (w_commit_done),
        .i_tail        (w_tail),
        .o_push        (w_push),
        .o_push_cmd    (w_push_cmd),
        .i_fifo_full   (w_fifo_full),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_data     (w_wr_data)
    );

    zdp_cmd_fifo u_cmd_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .o_full     (w_fifo_full),
        .i_pop      (w_cmd_pop),
        .o_valid    (w_cmd_valid),
        .o_cmd      (w_cmd)
    );

    zdp_pkt_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_pkt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    zdp_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PACKET_BYTES (PACKET_BYTES),
        .PW           (PW),
        .AW           (AW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_pop     (w_cmd_pop),
        .o_commit_done (w_commit_done),
        .o_tail        (w_tail),
        .o_rd_en       (w_rd_en),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_tx_byte     (o_tx_byte),
        .o_last_byte   (o_last_byte)
    );

endmodule

@@ rtl/zdp_pkt_ram.sv @@
// ----------------------------------------------------------------------------
// zdp_pkt_ram: packet store
// Byte-wide memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module zdp_pkt_ram #(
    parameter int DEPTH = 432,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/zdp_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// zdp_cmd_fifo: command queue between front end and transmit engine
// A short first-in first-out queue of commit and transmit commands.
// ----------------------------------------------------------------------------
module zdp_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  zdp_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output zdp_pkg::t_cmd o_cmd
);

    import zdp_pkg::*;

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cmd          r_mem [CMDQ_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == CW'(CMDQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(CMDQ_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (w_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/zdp_front.sv @@
// ----------------------------------------------------------------------------
// zdp_front: input front end and packet assembly
// Takes samples and ticks, writes distances straight into the free packet
// slot, zero fills and heads a finished packet, then queues a commit.
// ----------------------------------------------------------------------------
module zdp_front #(
    parameter int PACKET_BYTES = zdp_pkg::PACKET_BYTES_DEF,
    parameter int PW           = 4,
    parameter int AW           = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_func,
    input  logic [15:0]   i_distance,
    input  logic          i_commit_done,
    input  logic [PW-1:0] i_tail,
    output logic          o_push,
    output zdp_pkg::t_cmd o_push_cmd,
    input  logic          i_fifo_full,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data
);

    import zdp_pkg::*;

    localparam int SLOTS = (PACKET_BYTES - HEADER_BYTES) / 2;
    localparam int SW    = $clog2(SLOTS + 1);
    localparam int BW1   = $clog2(PACKET_BYTES + 1);

    t_front_state r_state, n_state;
    logic [SW-1:0]  r_slot;
    logic [6:0]     r_zone;
    logic [7:0]     r_pnum;
    logic [7:0]     r_dist_hi;
    logic [BW1-1:0] r_bidx;
    logic [7:0]     r_hdr_num;
    logic           r_hdr_mode;
    logic           r_pend;
    logic           r_zone_mode;

    logic [AW-1:0]  w_base;
    logic [AW-1:0]  w_slot_addr;
    logic           w_accept;
    logic [SW-1:0]  w_slot_inc;
    logic [6:0]     w_zone_inc;
    logic [6:0]     w_zones;
    logic           w_frame_end;
    logic           w_close;
    logic           w_pad_done;
    logic           w_hdr_done;

    assign w_base      = AW'(i_tail) * AW'(PACKET_BYTES);
    assign w_slot_addr = w_base + AW'(HEADER_BYTES) + (AW'(r_slot) << 1);
    assign w_slot_inc  = r_slot + SW'(1);
    assign w_zone_inc  = r_zone + 7'd1;
    assign w_zones     = (r_zone_mode == MODE_16) ? ZONES_16 : ZONES_64;
    assign w_frame_end = (w_zone_inc >= w_zones);
    assign w_close     = w_frame_end || (w_slot_inc >= SW'(SLOTS));
    assign w_pad_done  = (r_bidx >= BW1'(PACKET_BYTES));
    assign w_hdr_done  = (r_bidx == BW1'(HEADER_BYTES - 1));

    // A sample must wait while its slot's commit is still in the queue.
    assign o_in_stall = (r_state != F_IDLE) || i_fifo_full || (r_pend && !i_func);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (w_accept && (i_func == FUNC_SAMPLE)) begin
                    n_state = F_WR_HI;
                end
            end
            F_WR_HI: begin
                n_state = w_close ? F_PAD : F_IDLE;
            end
            F_PAD: begin
                if (w_pad_done) begin
                    n_state = F_HDR;
                end
            end
            F_HDR: begin
                if (w_hdr_done) begin
                    n_state = F_ISSUE;
                end
            end
            F_ISSUE: begin
                if (!i_fifo_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_wr_en    = 1'b0;
        o_wr_addr  = w_slot_addr;
        o_wr_data  = 8'd0;
        o_push     = 1'b0;
        o_push_cmd = CMD_TICK;
        case (r_state)
            F_IDLE: begin
                if (w_accept && (i_func == FUNC_SAMPLE)) begin
                    o_wr_en   = 1'b1;
                    o_wr_data = i_distance[7:0];
                end
                if (w_accept && (i_func == FUNC_TICK)) begin
                    o_push = 1'b1;
                end
            end
            F_WR_HI: begin
                o_wr_en   = 1'b1;
                o_wr_addr = w_slot_addr + AW'(1);
                o_wr_data = r_dist_hi;
            end
            F_PAD: begin
                o_wr_en   = !w_pad_done;
                o_wr_addr = w_base + AW'(r_bidx);
            end
            F_HDR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = w_base + AW'(r_bidx);
                case (r_bidx[1:0])
                    HDR_TYPE_POS: o_wr_data = PKT_TYPE;
                    HDR_NUM_POS:  o_wr_data = r_hdr_num;
                    HDR_CNT_POS:  o_wr_data = r_hdr_mode ? EXP_CNT_16 : EXP_CNT_64;
                    HDR_ID_POS:   o_wr_data = PKT_ID;
                    default:      o_wr_data = PKT_ID;
                endcase
            end
            F_ISSUE: begin
                o_push     = !i_fifo_full;
                o_push_cmd = CMD_COMMIT;
            end
            default: begin
                o_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dist_hi <= i_distance[15:8];
        end
        if ((r_state == F_WR_HI) && w_close) begin
            r_hdr_num  <= r_pnum;
            r_hdr_mode <= r_zone_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_slot      <= '0;
            r_zone      <= '0;
            r_pnum      <= 8'd1;
            r_bidx      <= '0;
            r_pend      <= 1'b0;
            r_zone_mode <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_zone_mode <= i_cfg_wr_data;
            end
            case (r_state)
                F_WR_HI: begin
                    if (w_close) begin
                        r_slot <= '0;
                        r_bidx <= BW1'(HEADER_BYTES) + (BW1'(w_slot_inc) << 1);
                        if (w_frame_end) begin
                            r_zone <= '0;
                            r_pnum <= 8'd1;
                        end else begin
                            r_zone <= w_zone_inc;
                            r_pnum <= r_pnum + 8'd1;
                        end
                    end else begin
                        r_slot <= w_slot_inc;
                        r_zone <= w_zone_inc;
                    end
                end
                F_PAD: begin
                    r_bidx <= w_pad_done ? '0 : r_bidx + BW1'(1);
                end
                F_HDR: begin
                    r_bidx <= r_bidx + BW1'(1);
                end
                default: begin
                    r_bidx <= r_bidx;
                end
            endcase
            if ((r_state == F_ISSUE) && !i_fifo_full) begin
                r_pend <= 1'b1;
            end else if (i_commit_done) begin
                r_pend <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/zdp_back.sv @@
// ----------------------------------------------------------------------------
// zdp_back: packet queue bookkeeping and transmit engine
// Executes commit and transmit commands in order: keeps the ring of packet
// slots and streams the head packet one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
module zdp_back #(
    parameter int QUEUE_DEPTH  = zdp_pkg::QUEUE_DEPTH_DEF,
    parameter int PACKET_BYTES = zdp_pkg::PACKET_BYTES_DEF,
    parameter int PW           = 4,
    parameter int AW           = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  zdp_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_commit_done,
    output logic [PW-1:0] o_tail,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_tx_byte,
    output logic          o_last_byte
);

    import zdp_pkg::*;

    localparam int BW1 = $clog2(PACKET_BYTES + 1);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);

    t_back_state r_state, n_state;
    logic [PW-1:0]  r_head;
    logic [PW-1:0]  r_tail;
    logic [CW-1:0]  r_count;
    logic [BW1-1:0] r_rd_idx;
    logic           r_have;
    logic           r_have_last;
    logic           r_out_valid;
    logic [7:0]     r_tx_byte;
    logic           r_last_byte;

    logic w_load;
    logic w_rd_last;
    logic w_commit;
    logic w_start;

    // The ring has one slot more than the queue holds, so the slot being
    // assembled never aliases a queued packet.
    function automatic logic [PW-1:0] slot_inc(input logic [PW-1:0] p);
        slot_inc = (p == PW'(QUEUE_DEPTH)) ? '0 : p + PW'(1);
    endfunction

    assign w_load    = r_have && (!r_out_valid || !i_out_stall);
    assign w_rd_last = (r_rd_idx == BW1'(PACKET_BYTES - 1));
    assign w_commit  = o_cmd_pop && (i_cmd == CMD_COMMIT);
    assign w_start   = o_cmd_pop && (i_cmd == CMD_TICK) && (r_count != '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (w_start) begin
                    n_state = B_STREAM;
                end
            end
            B_STREAM: begin
                if (o_rd_en && w_rd_last) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        o_rd_en   = 1'b0;
        case (r_state)
            B_IDLE: begin
                o_cmd_pop = i_cmd_valid;
            end
            B_STREAM: begin
                // A new read may replace the held byte only once it moves on.
                o_rd_en = !r_have || w_load;
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    assign o_rd_addr     = AW'(r_head) * AW'(PACKET_BYTES) + AW'(r_rd_idx);
    assign o_commit_done = w_commit;
    assign o_tail        = r_tail;
    assign o_out_valid   = r_out_valid;
    assign o_tx_byte     = r_tx_byte;
    assign o_last_byte   = r_last_byte;

    always_ff @(posedge i_clk) begin
        if (o_rd_en) begin
            r_have_last <= w_rd_last;
        end
        if (w_load) begin
            r_tx_byte   <= i_rd_data;
            r_last_byte <= r_have_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit && (r_count < CW'(QUEUE_DEPTH))) begin
                r_tail  <= slot_inc(r_tail);
                r_count <= r_count + CW'(1);
            end
            if (w_start) begin
                r_rd_idx <= '0;
            end else if (o_rd_en) begin
                r_rd_idx <= r_rd_idx + BW1'(1);
            end
            if (o_rd_en && w_rd_last) begin
                r_head  <= slot_inc(r_head);
                r_count <= r_count - CW'(1);
            end
            if (o_rd_en) begin
                r_have <= 1'b1;
            end else if (w_load) begin
                r_have <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("packet queue count exceeds its depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty packet queue with head and tail apart");

    a_stream_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_STREAM) |-> (r_count != '0))
        else $error("streaming from an empty packet queue");

    a_last_ends_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rd_en && w_rd_last) |=> (r_state == B_IDLE))
        else $error("transmit engine kept streaming past the last byte");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the zone distance packetizer
// A short scripted sequence and several random phases feed distance samples
// and transmit ticks under random gaps and receiver stalls. A behavioral
// framer predicts every transmitted byte, and each byte is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
    import zdp_pkg::*;

    localparam int QDEPTH        = QUEUE_DEPTH_DEF;
    localparam int PKT_BYTES     = PACKET_BYTES_DEF;
    localparam int SLOTS         = (PKT_BYTES - HEADER_BYTES) / 2;
    localparam int SETTLE_CYCLES = 100;
    localparam int NO_TYPED      = -1;
    localparam int MAX_REPORTS   = 100;
    localparam logic MODE_64     = 1'b0;

    typedef logic [PKT_BYTES*8-1:0] t_pkt;

    typedef struct packed {
        logic [7:0] tx;
        logic       last;
    } t_byte;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_SAMPLE,
        ROW_TICK
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] data;
        int          reps;
        int          exp_bytes;
    } t_row;

    // Scripted opening: a tick after reset, one full 16-zone packet with the
    // extreme distances, ticks on a queue holding that packet and on an empty
    // queue, and a partial 64-zone frame that must not produce a packet yet.
    localparam t_row SCRIPT [0:13] = '{
        '{ROW_TICK,   16'h0000,          1, 0},
        '{ROW_CFG,    {15'd0, MODE_16},  1, NO_TYPED},
        '{ROW_SAMPLE, 16'hFFFF,          1, NO_TYPED},
        '{ROW_SAMPLE, 16'h0000,          1, NO_TYPED},
        '{ROW_SAMPLE, 16'h8001,          1, NO_TYPED},
        '{ROW_SAMPLE, 16'h7FFE,          1, NO_TYPED},
        '{ROW_SAMPLE, 16'h00FF,          1, NO_TYPED},
        '{ROW_SAMPLE, 16'hFF00,          1, NO_TYPED},
        '{ROW_SAMPLE, 16'h5A5A,         10, NO_TYPED},
        '{ROW_TICK,   16'h0000,          1, PKT_BYTES},
        '{ROW_TICK,   16'hFFFF,          1, 0},
        '{ROW_CFG,    {15'd0, MODE_64},  1, NO_TYPED},
        '{ROW_SAMPLE, 16'hC3A5,          3, NO_TYPED},
        '{ROW_TICK,   16'h0000,          1, 0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_func;
    logic [15:0] i_distance;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_tx_byte;
    logic        o_last_byte;

    // Framer model state.
    logic        cur_mode   = MODE_64;
    logic [15:0] slot_buf [SLOTS];
    int          fill_pos   = 0;
    logic [7:0]  pkt_num    = 8'd1;
    int          zones_seen = 0;
    t_pkt        queued_pkts [$];
    int          dropped_pkts = 0;
    t_byte       pending_bytes [$];

    int          mismatches = 0;
    logic        in_pace    = 1'b1;
    logic        out_pace   = 1'b1;
    int          out_wait   = 0;
    t_byte       want;

    zone_distance_packetizer_fifo dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_distance    (i_distance),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_tx_byte     (o_tx_byte),
        .o_last_byte   (o_last_byte)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic flag(input string what, input int exp_val, input int got_val);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, got_val);
        end
    endtask

    // Closes the packet under assembly: queue it, or drop it when the queue
    // is full, and start a fresh zero-filled buffer either way.
    function automatic void seal_packet();
        t_pkt pkt;
        if (queued_pkts.size() >= QDEPTH) begin
            dropped_pkts++;
        end else begin
            pkt = '0;
            pkt[HDR_TYPE_POS*8 +: 8] = PKT_TYPE;
            pkt[HDR_NUM_POS*8 +: 8]  = pkt_num;
            pkt[HDR_CNT_POS*8 +: 8]  = (cur_mode == MODE_16) ? EXP_CNT_16 : EXP_CNT_64;
            pkt[HDR_ID_POS*8 +: 8]   = PKT_ID;
            for (int i = 0; i < SLOTS; i++) begin
                pkt[(HEADER_BYTES + 2*i)*8 +: 16] = slot_buf[i];
            end
            queued_pkts.push_back(pkt);
        end
        slot_buf = '{default: '0};
        fill_pos = 0;
    endfunction

    // Applies one accepted word to the model and returns how many bytes it
    // will make the block transmit.
    function automatic int frame_word(input logic f, input logic [15:0] d);
        t_pkt pkt;
        int   zones;
        if (f == FUNC_SAMPLE) begin
            zones = (cur_mode == MODE_16) ? int'(ZONES_16) : int'(ZONES_64);
            slot_buf[fill_pos] = d;
            fill_pos++;
            zones_seen++;
            if (zones_seen >= zones) begin
                seal_packet();
                pkt_num    = 8'd1;
                zones_seen = 0;
            end else if (fill_pos >= SLOTS) begin
                seal_packet();
                pkt_num = pkt_num + 8'd1;
            end
            return 0;
        end
        if (queued_pkts.size() == 0) begin
            return 0;
        end
        pkt = queued_pkts.pop_front();
        for (int i = 0; i < PKT_BYTES; i++) begin
            pending_bytes.push_back(t_byte'{pkt[i*8 +: 8], i == PKT_BYTES - 1});
        end
        return PKT_BYTES;
    endfunction

    task automatic send_word(input logic f, input logic [15:0] d, output int n_bytes);
        int gap;
        if ($urandom_range(0, 15) == 0) begin
            in_pace = !in_pace;
        end
        gap = in_pace ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_distance <= d;
        do @(posedge i_clk); while (o_in_stall);
        n_bytes = frame_word(f, d);
    endtask

    task automatic random_word(input int tick_pct);
        logic [15:0] d;
        logic        f;
        int          n;
        case ($urandom_range(0, 7))
            0:       d = 16'h0000;
            1:       d = 16'hFFFF;
            default: d = 16'($urandom_range(0, 65535));
        endcase
        f = ($urandom_range(0, 99) < tick_pct) ? FUNC_TICK : FUNC_SAMPLE;
        send_word(f, d, n);
    endtask

    // A packet may still be in assembly after the last byte has left, since
    // samples themselves produce no output; the settle time covers that.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_zone_mode(input logic m);
        wait_quiet();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_mode = m;
    endtask

    task automatic run_phase(input logic m, input int items, input int tick_pct,
                             input int stop_zone);
        set_zone_mode(m);
        repeat (items) random_word(tick_pct);
        // Leaving the frame part way lets the next mode change land mid-frame.
        while (zones_seen < stop_zone) random_word(0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: byte with nothing pending, expected none, got %0d",
                             $time, o_tx_byte);
                end
            end else begin
                want = pending_bytes.pop_front();
                if (o_tx_byte !== want.tx) begin
                    flag("tx_byte", want.tx, o_tx_byte);
                end
                if (o_last_byte !== want.last) begin
                    flag("last_byte", want.last, o_last_byte);
                end
            end
            if ($urandom_range(0, 15) == 0) begin
                out_pace = !out_pace;
            end
            out_wait = out_pace ? $urandom_range(0, 8) : 0;
        end else if (out_wait != 0) begin
            out_wait--;
        end
        i_out_stall <= (out_wait != 0);
    end

    initial begin
        int n;
        int drop_mark;
        slot_buf = '{default: '0};
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        i_in_valid    <= 1'b0;
        i_func        <= FUNC_SAMPLE;
        i_distance    <= 16'h0000;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (SCRIPT[r]) begin
            case (SCRIPT[r].kind)
                ROW_CFG: begin
                    set_zone_mode(SCRIPT[r].data[0]);
                end
                ROW_SAMPLE: begin
                    for (int k = 0; k < SCRIPT[r].reps; k++) begin
                        send_word(FUNC_SAMPLE, SCRIPT[r].data + 16'(k), n);
                    end
                end
                default: begin
                    send_word(FUNC_TICK, SCRIPT[r].data, n);
                    if (SCRIPT[r].exp_bytes != NO_TYPED && n != SCRIPT[r].exp_bytes) begin
                        flag("bytes per tick", SCRIPT[r].exp_bytes, n);
                    end
                end
            endcase
        end

        run_phase(MODE_64, 14, 15, 20);

        // The switch to 16 zones lands mid-frame, so the next sample ends it.
        // Fill the packet queue until two packets are dropped, then drain it
        // and tick a couple more times on the empty queue.
        set_zone_mode(MODE_16);
        drop_mark = dropped_pkts;
        while (dropped_pkts < drop_mark + 2) random_word(0);
        while (queued_pkts.size() != 0) send_word(FUNC_TICK, 16'($urandom_range(0, 65535)), n);
        repeat (2) send_word(FUNC_TICK, 16'($urandom_range(0, 65535)), n);

        run_phase(MODE_16, 20, 25, 0);

        wait_quiet();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
